// File: hw/rtl/packet_rate_pacer_macros.svh
// ============================================================================
// Packet rate pacer assertion macros
// Shared concurrent assertion forms for the pacer checker.
// ============================================================================
`ifndef PACKET_RATE_PACER_MACROS_SVH
`define PACKET_RATE_PACER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pacer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pacer check failed");

`endif

// File: hw/rtl/prp_pkg.sv
// ============================================================================
// Packet rate pacer package
// Payload types, sequencer states and constants shared by the pacer files.
// ============================================================================
package prp_pkg;

    localparam int MAX_PACKET_BYTES_DEFAULT = 16384;

    localparam int ACCOUNT_CAP     = 1500;
    localparam int OVERHEAD_BYTES  = 48;
    localparam int MS_PER_S        = 1000;
    localparam int MIN_RATE        = 1000;
    localparam int CONNECT_MIN_MS  = 1000;

    localparam int RATE_W   = 17;
    localparam int BYTES_W  = 15;
    localparam int SNAP_W   = 16;
    localparam int TOTAL_W  = 31;
    localparam int TIME_W   = 32;

    // Numerator of the byte-rate delay: at most (1500 + 48) * 1000.
    localparam int NUM_W     = $clog2((ACCOUNT_CAP + OVERHEAD_BYTES) * MS_PER_S + 1);
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int BCAP_W    = $clog2(ACCOUNT_CAP + OVERHEAD_BYTES + 1);

    localparam logic [TOTAL_W-1:0] COUNT_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] MODE_SNAPSHOT    = 2'd0;
    localparam logic [1:0] MODE_FRAGMENT    = 2'd1;
    localparam logic [1:0] MODE_FRAME_START = 2'd2;

    localparam int  PADDR_W       = 3;
    localparam logic ADDR_MAX_RATE = 1'b0;   // paddr[2] selects the register

    typedef struct packed {
        logic [1:0]         mode;
        logic [BYTES_W-1:0] byte_count;
        logic [RATE_W-1:0]  client_rate;
        logic [SNAP_W-1:0]  snapshot_interval_ms;
        logic signed [TIME_W-1:0] now_ms;
        logic               local_link;
        logic               client_active;
        logic               downloading;
    } prp_in_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] next_send_ms;
        logic               rate_delayed;
        logic               delayed_valid;
        logic [TOTAL_W-1:0] frame_bytes;
    } prp_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADJUST,
        ST_RESULT
    } prp_state_t;

endpackage

// File: hw/rtl/packet_rate_pacer.sv
// ============================================================================
// Packet rate pacer
// Computes the next allowed send time for a client after each packet event.
// ============================================================================
//
//  Channel   Ports                         Direction  Carries
//  -------   ---------------------------   ---------  --------------------------
//  input     s_valid / s_ready / s_data    in         one packet event (prp_in_t)
//  result    m_valid / m_ready / m_data    out        next send time (prp_out_t)
//  config    psel/penable/pwrite/paddr/... in         max_rate register at 0x0
//
// Each transaction goes through a capture step, then the shared restoring
// subtractor that forms the byte-rate quotient one bit per cycle, then a
// step that applies the snapshot interval and connecting minimum, and a
// last step that adds the current time and updates the frame
// counter. s_ready is high only while the sequencer is idle.
// A stalled result holds in the output register; the sequencer waits in its
// last step until that register is free, and may accept a new transaction
// while the previous result still waits. Reset is synchronous and active low
// and needs no clearing pass.
//
module packet_rate_pacer
    import prp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  prp_in_t             s_data,

    output logic                m_valid,
    input  logic                m_ready,
    output prp_out_t            m_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Width used to clamp the byte count for the frame counter. It covers
    // both the byte count field and the largest allowed packet size.
    localparam int ADD_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W = (ADD_W > BYTES_W) ? ADD_W : BYTES_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PACKET_BYTES);

    prp_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [RATE_W-1:0]    div_reg, div_next;
    prp_in_t              item_reg, item_next;
    logic [TIME_W-1:0]    delay_reg, delay_next;
    logic                 delayed_reg, delayed_next;
    logic                 valid_reg, valid_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [RATE_W-1:0]    max_rate_reg, max_rate_next;
    logic                 m_valid_reg, m_valid_next;
    prp_out_t             m_data_reg, m_data_next;

    // ------------------------------------------------------------------
    // Configuration port. Only paddr[2] is decoded, so any address below
    // 4 reaches max_rate and any address from 4 up falls outside the map.
    // ------------------------------------------------------------------
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == ADDR_MAX_RATE);
    assign prdata    = (paddr[2] == ADDR_MAX_RATE) ? {{(32-RATE_W){1'b0}}, max_rate_reg}
                                                   : 32'd0;
    assign max_rate_next = cfg_write ? pwdata[RATE_W-1:0] : max_rate_reg;

    // ------------------------------------------------------------------
    // Operand setup at acceptance: clamp the bytes, form the numerator
    // with one small constant multiply, and pick the effective rate.
    // ------------------------------------------------------------------
    logic [BCAP_W-1:0] bytes_acct;
    logic [NUM_W-1:0]  numerator;
    logic [RATE_W-1:0] cap_eff;
    logic [RATE_W-1:0] rate_eff;

    always_comb begin
        if (s_data.byte_count > BYTES_W'(ACCOUNT_CAP)) begin
            bytes_acct = BCAP_W'(ACCOUNT_CAP + OVERHEAD_BYTES);
        end else begin
            bytes_acct = BCAP_W'(s_data.byte_count) + BCAP_W'(OVERHEAD_BYTES);
        end
        numerator = NUM_W'(bytes_acct) * NUM_W'(MS_PER_S);

        // A nonzero cap below the floor acts as the floor.
        cap_eff = (max_rate_reg < RATE_W'(MIN_RATE)) ? RATE_W'(MIN_RATE) : max_rate_reg;
        if ((max_rate_reg != '0) && (cap_eff < s_data.client_rate)) begin
            rate_eff = cap_eff;
        end else begin
            rate_eff = s_data.client_rate;
        end
        if (rate_eff == '0) begin
            rate_eff = RATE_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Shared restoring subtractor: one quotient bit per cycle.
    // ------------------------------------------------------------------
    logic [RATE_W:0] trial;
    logic [RATE_W:0] diff;
    logic            trial_ge;

    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign trial_ge = !diff[RATE_W];

    // ------------------------------------------------------------------
    // Delay adjustment and final result terms.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]   snap_ext;
    logic               below_snap;
    logic [NUM_W-1:0]   delay_snap;
    logic [NUM_W-1:0]   delay_conn;
    logic               is_snapshot;
    logic               is_remote_snap;
    logic [CMP_W-1:0]   add_bytes;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_sat;
    logic [TIME_W-1:0]  next_time;

    always_comb begin
        snap_ext       = NUM_W'(item_reg.snapshot_interval_ms);
        below_snap     = quo_reg < snap_ext;
        delay_snap     = below_snap ? snap_ext : quo_reg;
        is_snapshot    = item_reg.mode == MODE_SNAPSHOT;
        is_remote_snap = is_snapshot && !item_reg.local_link;

        // Connecting clients that are not downloading wait at least the
        // connecting minimum.
        if (!item_reg.client_active && !item_reg.downloading
            && (delay_snap < NUM_W'(CONNECT_MIN_MS))) begin
            delay_conn = NUM_W'(CONNECT_MIN_MS);
        end else begin
            delay_conn = delay_snap;
        end

        if (CMP_W'(item_reg.byte_count) > MAX_CMP) begin
            add_bytes = MAX_CMP;
        end else begin
            add_bytes = CMP_W'(item_reg.byte_count);
        end
        total_sum = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(add_bytes);
        total_sat = total_sum[TOTAL_W] ? COUNT_MAX : total_sum[TOTAL_W-1:0];

        next_time = TIME_W'(item_reg.now_ms) + delay_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_next     = div_reg;
        item_next    = item_reg;
        delay_next   = delay_reg;
        delayed_next = delayed_reg;
        valid_next   = valid_reg;
        total_next   = total_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_data;
                    quo_next   = numerator;
                    rem_next   = '0;
                    div_next   = rate_eff;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV: begin
                rem_next = trial_ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], trial_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_ADJUST;
                end
            end

            ST_ADJUST: begin
                delayed_next = 1'b0;
                valid_next   = 1'b0;
                if (is_snapshot && item_reg.local_link) begin
                    // Adding all ones gives now - 1.
                    delay_next = {TIME_W{1'b1}};
                end else if (is_snapshot) begin
                    delay_next   = TIME_W'(delay_conn);
                    delayed_next = !below_snap;
                    valid_next   = 1'b1;
                end else begin
                    delay_next = TIME_W'(quo_reg);
                end
                state_next = ST_RESULT;
            end

            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    case (item_reg.mode)
                        MODE_SNAPSHOT: begin
                            if (is_remote_snap) begin
                                total_next = total_sat;
                            end
                            m_data_next.next_send_ms = next_time;
                            m_data_next.frame_bytes  = is_remote_snap ? total_sat : total_reg;
                        end
                        MODE_FRAGMENT: begin
                            m_data_next.next_send_ms = next_time;
                            m_data_next.frame_bytes  = total_reg;
                        end
                        MODE_FRAME_START: begin
                            total_next               = '0;
                            m_data_next.next_send_ms = '0;
                            m_data_next.frame_bytes  = '0;
                        end
                        default: begin
                            m_data_next.next_send_ms = '0;
                            m_data_next.frame_bytes  = total_reg;
                        end
                    endcase
                    m_data_next.rate_delayed  = delayed_reg;
                    m_data_next.delayed_valid = valid_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            total_reg    <= '0;
            max_rate_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            total_reg    <= total_next;
            max_rate_reg <= max_rate_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_reg     <= div_next;
        item_reg    <= item_next;
        delay_reg   <= delay_next;
        delayed_reg <= delayed_next;
        valid_reg   <= valid_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/prp_checker.sv
// ============================================================================
// Packet rate pacer checker
// Port-level checks of the pacer, attached to the top level by bind.
// ============================================================================
`include "packet_rate_pacer_macros.svh"

module prp_checker
    import prp_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input prp_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input prp_out_t m_data
);

    // A stalled result keeps its valid and its payload.
    `PRP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // The block works on one transaction at a time.
    `PRP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // The rate flag is only reported together with its update strobe.
    `PRP_ASSERT_IMPLY(a_delayed_needs_valid, aclk, aresetn, m_valid && m_data.rate_delayed,
                      m_data.delayed_valid)

endmodule

bind packet_rate_pacer prp_checker u_prp_checker (.*);

// File: dv/tb_packet_rate_pacer.sv
// ----------------------------------------------------------------------------
// Packet rate pacer testbench
// Sends packet events through the valid/ready input channel and checks every
// paced result against a predictor in this file. The max_rate register is
// written and read back over the APB port between phases. The run starts
// with directed events and then moves to random traffic under several
// sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_packet_rate_pacer;
    import prp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The mode encoding leaves one value unused. The block must ignore it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [PADDR_W-1:0] MAX_RATE_ADDR = {ADDR_MAX_RATE, 2'b00};

    // The settle wait after the last result covers one transaction inside
    // the block with margin.
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int EVENTS_PER_PHASE = 205;

    logic     aclk;
    logic     aresetn = 1'b0;

    logic     s_valid = 1'b0;
    logic     s_ready;
    prp_in_t  s_data  = '0;

    logic     m_valid;
    logic     m_ready = 1'b0;
    prp_out_t m_data;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Events waiting for the driver, and paced results that the block owes.
    prp_in_t  pending_events[$];
    prp_out_t expected_pacing[$];
    prp_out_t oldest_pacing;

    // Predictor copy of the register and of the per-frame byte counter.
    logic [RATE_W-1:0]  rate_cap_model   = '0;
    logic [TOTAL_W-1:0] frame_total_model = '0;

    // Idle percentages of the current phase.
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    logic s_taken = 1'b0;
    int   quiet_cycles = 0;
    int   mismatch_count = 0;

    packet_rate_pacer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Byte-rate delay in ms. Only the first 1500 bytes count, plus the
    // per-packet overhead. The client rate is limited by the cap register
    // when that is nonzero, and a small nonzero cap counts as the minimum
    // rate. A rate of zero is treated as one byte per second.
    function automatic logic [31:0] byte_rate_delay(logic [BYTES_W-1:0] bytes,
                                                    logic [RATE_W-1:0] rate);
        logic [31:0] counted;
        logic [31:0] eff_rate;
        logic [31:0] cap;
        counted  = (bytes > ACCOUNT_CAP) ? 32'(ACCOUNT_CAP) : {17'b0, bytes};
        eff_rate = {15'b0, rate};
        cap      = {15'b0, rate_cap_model};
        if (cap != 0) begin
            if (cap < MIN_RATE) begin
                cap = MIN_RATE;
            end
            if (cap < eff_rate) begin
                eff_rate = cap;
            end
        end
        if (eff_rate == 0) begin
            eff_rate = 1;
        end
        return ((counted + OVERHEAD_BYTES) * MS_PER_S) / eff_rate;
    endfunction

    // Works out the paced result of one packet event and advances the
    // frame byte counter the same way the block does.
    function automatic prp_out_t pace_event(prp_in_t ev);
        prp_out_t    res;
        logic [31:0] delay;
        logic [31:0] added;
        res = '0;
        case (ev.mode)
            MODE_SNAPSHOT: begin
                if (ev.local_link) begin
                    // A LAN client may be sent to again right away.
                    res.next_send_ms = ev.now_ms - 1;
                end else begin
                    delay = byte_rate_delay(ev.byte_count, ev.client_rate);
                    if (delay < {16'b0, ev.snapshot_interval_ms}) begin
                        delay = {16'b0, ev.snapshot_interval_ms};
                        res.rate_delayed = 1'b0;
                    end else begin
                        res.rate_delayed = 1'b1;
                    end
                    res.delayed_valid = 1'b1;
                    // The connecting minimum is tested on the delay itself,
                    // so a wrapping clock does not disturb it.
                    if (!ev.client_active && !ev.downloading && delay < CONNECT_MIN_MS) begin
                        delay = CONNECT_MIN_MS;
                    end
                    res.next_send_ms = ev.now_ms + delay;
                    added = (ev.byte_count > MAX_PACKET_BYTES_DEFAULT) ?
                            32'(MAX_PACKET_BYTES_DEFAULT) : {17'b0, ev.byte_count};
                    if ({1'b0, frame_total_model} > {1'b0, COUNT_MAX} - added) begin
                        frame_total_model = COUNT_MAX;
                    end else begin
                        frame_total_model = frame_total_model + added[TOTAL_W-1:0];
                    end
                end
            end
            MODE_FRAGMENT: begin
                res.next_send_ms = ev.now_ms +
                                   byte_rate_delay(ev.byte_count, ev.client_rate);
            end
            MODE_FRAME_START: begin
                frame_total_model = '0;
            end
            default: begin
                // The unused mode leaves everything as it is.
            end
        endcase
        res.frame_bytes = frame_total_model;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic prp_in_t make_event(logic [1:0] mode, int unsigned bytes,
                                           int unsigned rate, int unsigned snap,
                                           logic [31:0] now, logic lan,
                                           logic active, logic dl);
        prp_in_t ev;
        ev.mode                 = mode;
        ev.byte_count           = bytes[BYTES_W-1:0];
        ev.client_rate          = rate[RATE_W-1:0];
        ev.snapshot_interval_ms = snap[SNAP_W-1:0];
        ev.now_ms               = now;
        ev.local_link           = lan;
        ev.client_active        = active;
        ev.downloading          = dl;
        return ev;
    endfunction

    // Random packet event. Most events are snapshots and fragments, with
    // frame starts often enough to keep the frame counter moving up and
    // back down. Sizes cluster near the 1500-byte accounting limit and the
    // rates near the 1000 bytes/s floor, where the arithmetic turns.
    function automatic prp_in_t random_packet_event();
        prp_in_t     ev;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            ev.mode = MODE_FRAME_START;
        end else if (pick < 13) begin
            ev.mode = MODE_UNUSED;
        end else if (pick < 33) begin
            ev.mode = MODE_FRAGMENT;
        end else begin
            ev.mode = MODE_SNAPSHOT;
        end
        case ($urandom_range(3))
            0:       ev.byte_count = BYTES_W'($urandom_range(200));
            1:       ev.byte_count = BYTES_W'($urandom_range(1700, 1300));
            2:       ev.byte_count = BYTES_W'($urandom_range(MAX_PACKET_BYTES_DEFAULT));
            default: ev.byte_count = BYTES_W'($urandom_range(32767));
        endcase
        case ($urandom_range(3))
            0:       ev.client_rate = RATE_W'($urandom_range(2000, 1));
            1:       ev.client_rate = RATE_W'($urandom_range(100000, 1));
            2:       ev.client_rate = RATE_W'($urandom_range(131071));
            default: ev.client_rate = RATE_W'($urandom_range(1100, 900));
        endcase
        case ($urandom_range(2))
            0:       ev.snapshot_interval_ms = SNAP_W'($urandom_range(100));
            1:       ev.snapshot_interval_ms = SNAP_W'($urandom_range(3000));
            default: ev.snapshot_interval_ms = SNAP_W'($urandom_range(65535));
        endcase
        if ($urandom_range(7) == 0) begin
            ev.now_ms = 32'h7FFF_FF00 + $urandom_range(255);
        end else begin
            ev.now_ms = $urandom;
        end
        ev.local_link    = ($urandom_range(99) < 20);
        ev.client_active = ($urandom_range(99) < 70);
        ev.downloading   = ($urandom_range(1) != 0);
        return ev;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%t mismatch on %s: expected 0x%08h, got 0x%08h",
                     $realtime, what, want, got);
        end
    endtask

    // Lets the driver empty its queue and the block return every owed
    // result, then waits out the block's latency so it is truly idle.
    // This is also where the sender stands still until nothing is owed.
    // The queues and s_valid are looked at on the rising edge, where the
    // driver's falling-edge updates have all settled.
    task automatic drain_and_settle();
        do begin
            @(posedge aclk);
        end while (pending_events.size() != 0 || s_valid || expected_pacing.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes the rate cap over APB and reads it back. The predictor copy
    // changes at the edge where the write completes.
    task automatic set_max_rate(logic [RATE_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = MAX_RATE_ADDR;
        pwdata  = {15'b0, value};
        @(negedge aclk);
        penable = 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        rate_cap_model = value;
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        if (prdata !== {15'b0, value}) begin
            note_mismatch("max_rate readback", {15'b0, value}, prdata);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge. A new transaction is
    // loaded only when the channel is empty or the last one was taken at
    // the previous rising edge, so valid never drops before acceptance.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_data  <= pending_events.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The result side stalls at random according to the phase.
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled on the rising edge. The result check
    // runs before the new expectation is queued, since a result that
    // leaves in the same cycle belongs to an older transaction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_pacing.size() == 0) begin
                    note_mismatch("unexpected result", '0, m_data.next_send_ms);
                end else begin
                    oldest_pacing = expected_pacing.pop_front();
                    if (m_data.next_send_ms !== oldest_pacing.next_send_ms) begin
                        note_mismatch("next_send_ms", oldest_pacing.next_send_ms,
                                      m_data.next_send_ms);
                    end
                    if (m_data.rate_delayed !== oldest_pacing.rate_delayed) begin
                        note_mismatch("rate_delayed", {31'b0, oldest_pacing.rate_delayed},
                                      {31'b0, m_data.rate_delayed});
                    end
                    if (m_data.delayed_valid !== oldest_pacing.delayed_valid) begin
                        note_mismatch("delayed_valid", {31'b0, oldest_pacing.delayed_valid},
                                      {31'b0, m_data.delayed_valid});
                    end
                    if (m_data.frame_bytes !== oldest_pacing.frame_bytes) begin
                        note_mismatch("frame_bytes", {1'b0, oldest_pacing.frame_bytes},
                                      {1'b0, m_data.frame_bytes});
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_pacing.push_back(pace_event(s_data));
            end
            // Watchdog: too long without a transaction on either channel
            // means the block has hung.
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned       sender_pct[4];
        int unsigned       receiver_pct[4];
        logic [RATE_W-1:0] cap_settings[RANDOM_PHASES];

        sender_pct   = '{0, 61, 0, 14};
        receiver_pct = '{0, 0, 61, 14};
        cap_settings =
            '{17'd1, 17'd999, 17'd1000, 17'd100000, 17'd131071, 17'd0, 17'd0, 17'd0};

        // Reset starts asserted and is released on a falling edge.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed events with the cap at its reset value of zero. They
        // cover the LAN shortcut, a zero rate, oversized packets, the
        // connecting minimum with and without a download, a delay that
        // exactly meets the interval, fragments, both frame starts and the
        // unused mode, and clock values that wrap.
        pending_events.push_back(make_event(MODE_SNAPSHOT, 1200, 5000, 0,
                                            32'h8000_0000, 1'b1, 1'b1, 1'b0));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 0, 0, 0,
                                            32'h0000_0000, 1'b0, 1'b1, 1'b0));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 32767, 131071, 65535,
                                            32'h7FFF_FFF0, 1'b0, 1'b1, 1'b1));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 16384, 100000, 0,
                                            32'h0000_0064, 1'b0, 1'b0, 1'b0));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 16385, 100000, 0,
                                            32'h7FFF_FF00, 1'b0, 1'b0, 1'b1));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 952, 1000, 1000,
                                            32'h0000_0005, 1'b0, 1'b1, 1'b0));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 952, 1000, 1001,
                                            32'h0000_0005, 1'b0, 1'b0, 1'b0));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 1500, 1, 0,
                                            32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 1501, 48, 500,
                                            32'h1234_5678, 1'b0, 1'b0, 1'b0));
        pending_events.push_back(make_event(MODE_FRAGMENT, 16384, 0, 65535,
                                            32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0));
        pending_events.push_back(make_event(MODE_FRAGMENT, 0, 131071, 0,
                                            32'h0000_0000, 1'b1, 1'b1, 1'b1));
        pending_events.push_back(make_event(MODE_UNUSED, 32767, 131071, 65535,
                                            32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
        pending_events.push_back(make_event(MODE_FRAME_START, 32767, 131071, 65535,
                                            32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 32767, 131071, 65535,
                                            32'h0000_0000, 1'b1, 1'b1, 1'b1));
        pending_events.push_back(make_event(MODE_SNAPSHOT, 700, 2000, 10,
                                            32'h4000_0000, 1'b0, 1'b1, 1'b1));
        pending_events.push_back(make_event(MODE_UNUSED, 0, 0, 0,
                                            32'h0000_0000, 1'b0, 1'b0, 1'b0));
        pending_events.push_back(make_event(MODE_FRAME_START, 0, 0, 0,
                                            32'h0000_0000, 1'b0, 1'b0, 1'b0));
        drain_and_settle();

        // Random phases. Each one sets a new cap while the block is idle,
        // including the floor, values below it, the top of the range
        // and zero, and then runs random traffic under one idle pattern.
        cap_settings[RANDOM_PHASES-1] = RATE_W'($urandom_range(131071, 1));
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_max_rate(cap_settings[ph]);
            sender_idle_pct    = sender_pct[ph % 4];
            receiver_stall_pct = receiver_pct[ph % 4];
            for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
                pending_events.push_back(random_packet_event());
            end
            drain_and_settle();
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
